/* hw/rtl/sdtq_pkg.sv */
`timescale 1ns / 1ps

package sdtq_pkg;

  localparam int TIMER_ID_W     = 4;
  localparam int TIME_W         = 48;
  localparam int PERIOD_W       = 32;
  localparam int FUNC_W         = 2;
  localparam int KIND_W         = 2;
  localparam int NUM_TIMERS_DEF = 16;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;

  // One queue position
  typedef struct packed {
    logic                  valid;
    logic [TIMER_ID_W-1:0] id;
    logic [TIME_W-1:0]     dl;
    logic [PERIOD_W-1:0]   per;
    logic                  periodic;
  } entry_t;

  // Status a cell shows to its neighbors and to the controller
  typedef struct packed {
    logic le;   // holds an entry with deadline <= key
    logic ge;   // holds an entry with deadline >= key
    logic rm;   // this cell or one to its left holds the key id
    logic fit;  // holds the key id and the key deadline keeps the row sorted
  } cell_stat_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_UPDATE,
    CMD_REMOVE,
    CMD_INSERT
  } cell_cmd_t;

  localparam entry_t     ENTRY_NONE = '0;
  localparam cell_stat_t STAT_HEAD  = '{le: 1'b1, ge: 1'b0, rm: 1'b0, fit: 1'b0};
  localparam cell_stat_t STAT_NONE  = '0;

endpackage

/* hw/rtl/sdtq_cell.sv */
`timescale 1ns / 1ps

module sdtq_cell import sdtq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  entry_t     key,
  input  entry_t     left,
  input  cell_stat_t left_stat,
  input  entry_t     right,
  input  cell_stat_t right_stat,
  output entry_t     ent,
  output cell_stat_t stat
);

  logic   match;
  entry_t ent_next;

  assign match    = ent.valid && (ent.id == key.id);
  assign stat.le  = ent.valid && (ent.dl <= key.dl);
  assign stat.ge  = ent.valid && (ent.dl >= key.dl);
  assign stat.rm  = left_stat.rm || match;
  assign stat.fit = match && left_stat.le && (!right.valid || right_stat.ge);

  always_comb begin
    ent_next = ent;
    case (cmd)
      CMD_UPDATE: begin
        if (match) begin
          ent_next.dl       = key.dl;
          ent_next.per      = key.per;
          ent_next.periodic = key.periodic;
        end
      end
      CMD_REMOVE: begin
        // close the gap: take from the right neighbor
        if (stat.rm) begin
          ent_next = right;
        end
      end
      CMD_INSERT: begin
        // keep earlier deadlines, load key at the boundary, shift the rest right
        if (!stat.le) begin
          if (left_stat.le) begin
            ent_next       = key;
            ent_next.valid = 1'b1;
          end else begin
            ent_next = left;
          end
        end
      end
      default: begin
        ent_next = ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

/* hw/rtl/sorted_deadline_timer_queue_unit.sv */
`timescale 1ns / 1ps
// Cancel and bad-id set results are registered at accept; a valid set evaluates, then
// updates in place or removes and inserts. A tick pops each due head: a dropped expiry
// is removed, a re-armed periodic timer is placed like a set. Cells take one evaluate,
// remove or insert step per cycle. One item at a time; a valid set or tick stays busy
// until its last result, if any, is issued. Reset (synchronous, rst high) clears time,
// live flags and the queue. Results are one-cycle strobes; the receiver cannot stall.

module sorted_deadline_timer_queue_unit import sdtq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func,
  input  logic [TIMER_ID_W-1:0] timer_id,
  input  logic [PERIOD_W-1:0]   delay,
  input  logic                  periodic,
  output logic                  strobe,
  output logic [KIND_W-1:0]     kind,
  output logic [TIMER_ID_W-1:0] timer_id_res,
  output logic                  became_head,
  output logic                  last
);

  localparam int ID_COUNT = 2 ** TIMER_ID_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MOVE,
    S_INSERT,
    S_POP,
    S_DROP
  } state_t;

  state_t                state;
  logic [TIME_W-1:0]     now;
  logic [TIME_W:0]       limit;      // one bit wider: now + 1 may reach 2^48
  entry_t                key;        // entry being placed or removed
  logic [ID_COUNT-1:0]   live;
  logic [ID_COUNT-1:0]   fired;      // popped during the current tick
  logic                  pending_valid;
  logic [TIMER_ID_W-1:0] pending_id;
  logic                  in_tick;
  logic                  fit_reg;
  logic                  head_reg;

  cell_cmd_t             cmd;
  entry_t                ents  [NUM_TIMERS];
  cell_stat_t            stats [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] fit_vec;

  logic                  id_ok;
  logic [PERIOD_W-1:0]   dly1;
  entry_t                head;
  logic                  due;
  logic                  place_done;
  logic                  place_head;

  // Row of cells, position 0 is the queue head
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t     left_ent, right_ent;
    cell_stat_t left_st, right_st;

    if (i == 0) begin : g_first
      assign left_ent = ENTRY_NONE;
      assign left_st  = STAT_HEAD;
    end else begin : g_mid_l
      assign left_ent = ents[i-1];
      assign left_st  = stats[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_last
      assign right_ent = ENTRY_NONE;
      assign right_st  = STAT_NONE;
    end else begin : g_mid_r
      assign right_ent = ents[i+1];
      assign right_st  = stats[i+1];
    end

    sdtq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .key        (key),
      .left       (left_ent),
      .left_stat  (left_st),
      .right      (right_ent),
      .right_stat (right_st),
      .ent        (ents[i]),
      .stat       (stats[i])
    );

    assign fit_vec[i] = stats[i].fit;
  end

  assign busy  = (state != S_IDLE);
  assign id_ok = (32'(timer_id) < NUM_TIMERS);
  // Zero delay is raised to one tick
  assign dly1  = (delay == '0) ? PERIOD_W'(1) : delay;
  assign head  = ents[0];
  // Head is due when it is not later than now + 1 and has not popped this tick
  assign due   = head.valid && ({1'b0, head.dl} <= limit) && !fired[head.id];

  // A placement ends either with an in-place update or after the insert step
  assign place_done = ((state == S_MOVE) && fit_reg) || (state == S_INSERT);
  assign place_head = (state == S_MOVE) ? head_reg : !stats[0].le;

  always_comb begin
    case (state)
      S_MOVE:   cmd = fit_reg ? CMD_UPDATE : CMD_REMOVE;
      S_INSERT: cmd = CMD_INSERT;
      S_DROP:   cmd = CMD_REMOVE;
      default:  cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      now           <= '0;
      live          <= '0;
      fired         <= '0;
      pending_valid <= 1'b0;
      in_tick       <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (func)
              FUNC_SET: begin
                if (id_ok) begin
                  // arm and start the placement
                  key          <= '{valid: 1'b1, id: timer_id, dl: now + TIME_W'(dly1),
                                    per: dly1, periodic: periodic};
                  live[timer_id] <= 1'b1;
                  in_tick      <= 1'b0;
                  state        <= S_EVAL;
                end else begin
                  // slot out of range: acknowledge only
                  strobe       <= 1'b1;
                  kind         <= KIND_SET;
                  timer_id_res <= timer_id;
                  became_head  <= 1'b0;
                  last         <= 1'b1;
                end
              end
              FUNC_CANCEL: begin
                // clear the live flag; the entry leaves silently when it comes due
                if (id_ok) begin
                  live[timer_id] <= 1'b0;
                end
                strobe       <= 1'b1;
                kind         <= KIND_CANCEL;
                timer_id_res <= timer_id;
                became_head  <= 1'b0;
                last         <= 1'b1;
              end
              FUNC_TICK: begin
                // limit is the advanced time plus one, taken after the time wraps
                now           <= now + TIME_W'(1);
                limit         <= {1'b0, now + TIME_W'(1)} + (TIME_W+1)'(1);
                fired         <= '0;
                pending_valid <= 1'b0;
                in_tick       <= 1'b1;
                state         <= S_POP;
              end
              default: begin
                // unused code: drop the item
              end
            endcase
          end
        end
        S_EVAL: begin
          // cells compare against the key this cycle; hold the verdict
          fit_reg  <= |fit_vec;
          head_reg <= stats[0].fit;
          state    <= S_MOVE;
        end
        S_MOVE: begin
          if (!fit_reg) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          // placement finishes below
        end
        S_POP: begin
          // hold a live expiry until the next live one or the end of the tick,
          // so only the final result carries last
          if (due) begin
            fired[head.id] <= 1'b1;
            if (live[head.id]) begin
              if (pending_valid) begin
                strobe       <= 1'b1;
                kind         <= KIND_EXPIRED;
                timer_id_res <= pending_id;
                became_head  <= 1'b0;
                last         <= 1'b0;
              end
              pending_valid <= 1'b1;
              pending_id    <= head.id;
            end
            if (live[head.id] && head.periodic) begin
              // re-arm one period later and re-sort
              key   <= '{valid: 1'b1, id: head.id, dl: head.dl + TIME_W'(head.per),
                         per: head.per, periodic: 1'b1};
              state <= S_EVAL;
            end else begin
              key.id <= head.id;
              state  <= S_DROP;
            end
          end else begin
            if (pending_valid) begin
              strobe       <= 1'b1;
              kind         <= KIND_EXPIRED;
              timer_id_res <= pending_id;
              became_head  <= 1'b0;
              last         <= 1'b1;
            end
            pending_valid <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_DROP: begin
          state <= S_POP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (place_done) begin
        if (in_tick) begin
          state <= S_POP;
        end else begin
          strobe       <= 1'b1;
          kind         <= KIND_SET;
          timer_id_res <= key.id;
          became_head  <= place_head;
          last         <= 1'b1;
          state        <= S_IDLE;
        end
      end
    end
  end

endmodule

/* hw/rtl/sdtq_checker.sv */
`timescale 1ns / 1ps

module sdtq_checker import sdtq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [FUNC_W-1:0]     func,
  input logic                  strobe,
  input logic [KIND_W-1:0]     kind,
  input logic                  became_head,
  input logic                  last
);

  // Expiries come only out of tick processing
  a_expiry_in_tick: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == KIND_EXPIRED) |-> $past(busy))
    else $error("expiry result outside tick processing");

  // Set and cancel make a single result
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind != KIND_EXPIRED) |-> last)
    else $error("acknowledge without last");

  // Head flag belongs to set results only
  a_head_set_only: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind != KIND_SET) |-> !became_head)
    else $error("became_head on a non-set result");

  // Cancel is acknowledged in the next cycle
  a_cancel_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (func == FUNC_CANCEL) |=> strobe && (kind == KIND_CANCEL))
    else $error("cancel not acknowledged");

  // More results follow a non-final one, so the block stays busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result while idle");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker u_sdtq_checker (.*);
